// ===== src/gsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

  localparam int unsigned PC_W = 64;
  localparam int unsigned CTR_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CTR_W-1:0] ctr_t;

  localparam ctr_t CTR_MAX = ctr_t'(3);
  localparam ctr_t CTR_MIN = ctr_t'(0);

  // Item modes
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_VALID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_CHECK_ENABLE = CFG_IDX_W'(1);

  // Saturating two-bit counter step.
  function automatic ctr_t ctr_next(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + ctr_t'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - ctr_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/gsp_clear_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sweep every table entry once after reset.
module gsp_clear_seq #(
  parameter int unsigned CNT_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  output logic                     active_o,
  output logic [CNT_BITS-1:0]      idx_o
);

  logic                active_q, active_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    active_d = active_q;
    cnt_d = cnt_q;
    if (active_q) begin
      cnt_d = cnt_q + CNT_BITS'(1);
      if (cnt_q == {CNT_BITS{1'b1}}) active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      active_q <= active_d;
      cnt_q <= cnt_d;
    end
  end

  assign active_o = active_q;
  assign idx_o = cnt_q;

endmodule

`default_nettype wire

// ===== src/gshare_predictor_with_tag_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gshare branch predictor with a tag table. Each item is a predict or an update
// for one branch pc. An item is taken on every clock edge where start_i is high
// and busy_o is low, so one item per cycle is sustained. A predict item passes
// through the stage 1 item registers and the result register and returns its
// direction on prediction_o, with result_valid_o high for exactly one cycle; the
// receiver cannot stall this and must sample it then. An update item returns
// nothing. The prediction is formed from the registered read of the pattern and
// tag memories. After reset the block sweeps both memories to their reset
// contents, one entry per cycle, over 2**max(HIST_BITS, TAG_INDEX_BITS) indexes
// (4096 with the defaults); busy_o stays high for that sweep and then stays low.
// Configuration writes are always taken (cfg_ready_o is tied high) and should
// only be issued while no item is in flight.
module gshare_predictor_with_tag_table #(
  parameter int unsigned HIST_BITS = 12,
  parameter int unsigned TAG_INDEX_BITS = 9,
  parameter int unsigned INIT_COUNTER = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          mode_i,
  input  wire logic [gsp_pkg::PC_W-1:0]      pc_i,
  input  wire logic                          outcome_i,
  output logic                               result_valid_o,
  output logic                               prediction_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic                          cfg_data_i
);

  localparam int unsigned PHT_DEPTH = 2 ** HIST_BITS;
  localparam int unsigned TAG_DEPTH = 2 ** TAG_INDEX_BITS;
  localparam int unsigned TAG_W = gsp_pkg::PC_W - TAG_INDEX_BITS - 2;
  // Pattern entry: {valid, counter}. Tag entry: {valid, tag}.
  localparam int unsigned PHT_W = gsp_pkg::CTR_W + 1;
  localparam int unsigned TENT_W = TAG_W + 1;
  localparam int unsigned CLR_BITS =
    (HIST_BITS > TAG_INDEX_BITS) ? HIST_BITS : TAG_INDEX_BITS;

  // ---------------------------------------------------------------------------
  // Reset sweep
  // ---------------------------------------------------------------------------
  logic                clr_active;
  logic [CLR_BITS-1:0] clr_idx;

  gsp_clear_seq #(
    .CNT_BITS(CLR_BITS)
  ) u_clear (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .active_o(clr_active),
    .idx_o   (clr_idx)
  );

  assign busy_o = clr_active;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic require_valid_q, tag_check_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_valid_q <= 1'b0;
      tag_check_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gsp_pkg::CFG_REQUIRE_VALID: require_valid_q <= cfg_data_i;
        gsp_pkg::CFG_TAG_CHECK_ENABLE: tag_check_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 item registers
  // ---------------------------------------------------------------------------
  logic                      s1_valid_q;
  logic                      s1_mode_q;
  logic                      s1_outcome_q;
  logic [HIST_BITS-1:0]      s1_pidx_q;
  logic [TAG_INDEX_BITS-1:0] s1_set_q;
  logic [TAG_W-1:0]          s1_tag_q;
  logic                      s1_upd;

  assign s1_upd = s1_valid_q && (s1_mode_q == gsp_pkg::MODE_UPDATE);

  // History as the next item sees it: an update in stage 1 shifts in now.
  logic [HIST_BITS-1:0] hist_q, hist_d;

  assign hist_d = s1_upd ? HIST_BITS'({hist_q, s1_outcome_q}) : hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  logic                      accept;
  logic [HIST_BITS-1:0]      new_pidx;
  logic [TAG_INDEX_BITS-1:0] new_set;
  logic [TAG_W-1:0]          new_tag;

  assign accept = start_i && !clr_active;
  assign new_pidx = hist_d ^ pc_i[HIST_BITS+1:2];
  assign new_set = pc_i[TAG_INDEX_BITS+1:2];
  assign new_tag = pc_i[gsp_pkg::PC_W-1:TAG_INDEX_BITS+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= mode_i;
      s1_outcome_q <= outcome_i;
      s1_pidx_q <= new_pidx;
      s1_set_q <= new_set;
      s1_tag_q <= new_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Pattern and tag memories
  // ---------------------------------------------------------------------------
  logic [PHT_W-1:0]  pht_mem [PHT_DEPTH];
  logic [TENT_W-1:0] tag_mem [TAG_DEPTH];

  logic [PHT_W-1:0]  pht_rdata_q;
  logic [TENT_W-1:0] tag_rdata_q;

  logic                      pht_we, tag_we;
  logic [HIST_BITS-1:0]      pht_waddr;
  logic [TAG_INDEX_BITS-1:0] tag_waddr;
  logic [PHT_W-1:0]          pht_wdata;
  logic [TENT_W-1:0]         tag_wdata;

  // Forward the write of an update in stage 1 to the item read at the same edge.
  logic              pht_byp_q, tag_byp_q;
  logic [PHT_W-1:0]  pht_byp_data_q;
  logic [TENT_W-1:0] tag_byp_data_q;

  logic [PHT_W-1:0]  pht_ent;
  logic [TENT_W-1:0] tag_ent;
  gsp_pkg::ctr_t     ctr_cur, ctr_upd;

  assign pht_ent = pht_byp_q ? pht_byp_data_q : pht_rdata_q;
  assign tag_ent = tag_byp_q ? tag_byp_data_q : tag_rdata_q;
  assign ctr_cur = pht_ent[gsp_pkg::CTR_W-1:0];
  assign ctr_upd = gsp_pkg::ctr_next(ctr_cur, s1_outcome_q);

  always_comb begin
    pht_we = s1_upd;
    pht_waddr = s1_pidx_q;
    pht_wdata = {1'b1, ctr_upd};
    tag_we = s1_upd;
    tag_waddr = s1_set_q;
    tag_wdata = {1'b1, s1_tag_q};
    if (clr_active) begin
      // Drop to reset contents: counter at its initial value, nothing valid.
      pht_we = 1'b1;
      pht_waddr = clr_idx[HIST_BITS-1:0];
      pht_wdata = {1'b0, gsp_pkg::CTR_W'(INIT_COUNTER)};
      tag_we = 1'b1;
      tag_waddr = clr_idx[TAG_INDEX_BITS-1:0];
      tag_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pht_we) pht_mem[pht_waddr] <= pht_wdata;
    pht_rdata_q <= pht_mem[new_pidx];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_rdata_q <= tag_mem[new_set];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pht_byp_q <= 1'b0;
      tag_byp_q <= 1'b0;
    end else begin
      pht_byp_q <= s1_upd && (s1_pidx_q == new_pidx);
      tag_byp_q <= s1_upd && (s1_set_q == new_set);
    end
  end

  always_ff @(posedge clk_i) begin
    pht_byp_data_q <= pht_wdata;
    tag_byp_data_q <= tag_wdata;
  end

  // ---------------------------------------------------------------------------
  // Prediction and result register
  // ---------------------------------------------------------------------------
  logic tag_hit, taken;

  assign tag_hit = tag_ent[TAG_W] && (tag_ent[TAG_W-1:0] == s1_tag_q);
  assign taken = ctr_cur[gsp_pkg::CTR_W-1]
              && (!require_valid_q || pht_ent[gsp_pkg::CTR_W])
              && (!tag_check_q || tag_hit);

  logic res_valid_q, res_pred_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q && (s1_mode_q == gsp_pkg::MODE_PREDICT);
    end
  end

  always_ff @(posedge clk_i) begin
    res_pred_q <= taken;
  end

  assign result_valid_o = res_valid_q;
  assign prediction_o = res_pred_q;

endmodule

`default_nettype wire

// ===== src/gsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic mode_i,
  input wire logic result_valid_o
);

  logic acc_pred, acc_upd;

  assign acc_pred = start_i && !busy_o && (mode_i == gsp_pkg::MODE_PREDICT);
  assign acc_upd = start_i && !busy_o && (mode_i == gsp_pkg::MODE_UPDATE);

  // Once the reset sweep ends, busy never returns.
  a_busy_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after the reset sweep");

  a_pred_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pred |-> ##2 result_valid_o)
    else $error("predict item produced no result");

  a_upd_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_upd |-> ##2 !result_valid_o)
    else $error("update item produced a result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(acc_pred, 2))
    else $error("result without a predict item");

endmodule

bind gshare_predictor_with_tag_table gsp_checker u_gsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .mode_i        (mode_i),
  .result_valid_o(result_valid_o)
);

`default_nettype wire
